// ===== src/fws_pkg.sv =====
`default_nettype none
package fws_pkg;

   localparam int TS_W      = 40;
   localparam int TAG_W     = 16;
   localparam int WIN_W     = 26;
   localparam int SPW_W     = 7;
   localparam int MINR_W    = 10;
   localparam int SLOT_W    = 6;
   localparam int FRAMES_W  = 11;
   localparam int RATE_W    = 24;
   localparam int STS_W     = 3;
   localparam int SCALED_W  = TS_W + SPW_W;
   localparam int US_W      = 20;
   localparam int Q_FRAC_W  = 8;
   localparam int CSR_IDX_W = 2;

   localparam int US_PER_SEC      = 1000000;
   localparam int FRAME_SLOTS_DEF = 1024;
   localparam int MAX_SLOTS_DEF   = 64;
   localparam int QUEUE_DEPTH     = 2;
   localparam int FRAMES_MAX      = 2047;

   localparam logic [WIN_W-1:0]  WINDOW_RST   = WIN_W'(10000000);
   localparam logic [SPW_W-1:0]  SAMPLES_RST  = SPW_W'(64);
   localparam logic [MINR_W-1:0] MIN_RATE_RST = MINR_W'(15);
   localparam logic [WIN_W-1:0]  MAX_GAP_RST  = WIN_W'(750000);

   localparam logic [WIN_W-1:0]  GAP_SAT  = '1;
   localparam logic [RATE_W-1:0] RATE_SAT = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW,
      CSR_SAMPLES,
      CSR_MIN_RATE,
      CSR_MAX_GAP
   } csr_index_type;

   typedef enum logic [STS_W-1:0] {
      ST_BAD_TIME,
      ST_EMPTY,
      ST_BAD_FORMAT,
      ST_NONMONO,
      ST_SAMPLING,
      ST_LOW_RATE,
      ST_GAP,
      ST_READY
   } status_type;

   typedef struct packed {
      logic [WIN_W-1:0]  window_us;
      logic [SPW_W-1:0]  samples_per_window;
      logic [MINR_W-1:0] min_rate_fps;
      logic [WIN_W-1:0]  max_gap_us;
   } fws_cfg_type;

   typedef struct packed {
      logic              reject;
      status_type        status;
      logic [TS_W-1:0]   timestamp;
      logic [TAG_W-1:0]  tag;
   } fws_item_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [TAG_W-1:0]    tag;
      logic [FRAMES_W-1:0] frames;
      logic [WIN_W-1:0]    gap;
      logic [RATE_W-1:0]   rate;
      logic                last;
   } fws_result_type;

   function automatic fws_result_type plain_result(input status_type st);
      fws_result_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/fws_channels.sv =====
`default_nettype none
interface fws_req_if;
   logic                      valid;
   logic                      ready;
   logic [fws_pkg::TS_W-1:0]  timestamp_us;
   logic                      time_ok;
   logic                      roi_empty;
   logic                      format_bad;
   logic [fws_pkg::TAG_W-1:0] frame_tag;

   modport source(output valid, timestamp_us, time_ok, roi_empty, format_bad, frame_tag,
                  input ready);
   modport sink(input valid, timestamp_us, time_ok, roi_empty, format_bad, frame_tag,
                output ready);
endinterface

interface fws_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fws_pkg::STS_W-1:0]    status_code;
   logic [fws_pkg::SLOT_W-1:0]   slot_index;
   logic [fws_pkg::TAG_W-1:0]    chosen_tag;
   logic [fws_pkg::FRAMES_W-1:0] window_frames;
   logic [fws_pkg::WIN_W-1:0]    largest_gap_us;
   logic [fws_pkg::RATE_W-1:0]   rate_q8;
   logic                         last_of_run;

   modport source(output valid, status_code, slot_index, chosen_tag, window_frames,
                  largest_gap_us, rate_q8, last_of_run, input ready);
   modport sink(input valid, status_code, slot_index, chosen_tag, window_frames,
                largest_gap_us, rate_q8, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== src/frame_window_sampler.sv =====
`default_nettype none
// Frame window sampler. Each word on req_bus is one frame event; words with bad
// flags or a timestamp not above the newest stored one are rejected with a
// single status word. Accepted frames go into a ring of FRAME_SLOTS
// (timestamp, tag) pairs held in memory with one write and one registered read
// port; once the ring covers a whole window, rate and gap checks run and, when
// both pass, one word per sample slot comes out on rsp_bus naming the nearest
// frame. Events are taken into a small queue while earlier ones are still in
// work. An accepted event walks the aged-out entries and the ring, runs the
// serial rate divider, then for each slot advances the nearest frame; the
// registered memory read per visited entry sets the pace. Configuration
// writes are taken at any time but must only be issued while the block is
// idle.
module frame_window_sampler #(
   parameter int FRAME_SLOTS = fws_pkg::FRAME_SLOTS_DEF,
   parameter int MAX_SLOTS   = fws_pkg::MAX_SLOTS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [fws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fws_pkg::WIN_W-1:0]      csr_wdata,
   fws_req_if.sink                             req_bus,
   fws_rsp_if.source                           rsp_bus
);

   fws_pkg::fws_cfg_type  cfg_ff;
   fws_pkg::fws_item_type front_item;
   logic                  front_valid;
   logic                  front_ready;
   fws_pkg::fws_item_type queue_item;
   logic                  queue_valid;
   logic                  queue_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_us          <= fws_pkg::WINDOW_RST;
         cfg_ff.samples_per_window <= fws_pkg::SAMPLES_RST;
         cfg_ff.min_rate_fps       <= fws_pkg::MIN_RATE_RST;
         cfg_ff.max_gap_us         <= fws_pkg::MAX_GAP_RST;
      end else if (csr_we) begin
         unique case (fws_pkg::csr_index_type'(csr_index))
            fws_pkg::CSR_WINDOW:   cfg_ff.window_us <= csr_wdata;
            fws_pkg::CSR_SAMPLES:
               cfg_ff.samples_per_window <= csr_wdata[fws_pkg::SPW_W-1:0];
            fws_pkg::CSR_MIN_RATE:
               cfg_ff.min_rate_fps <= csr_wdata[fws_pkg::MINR_W-1:0];
            fws_pkg::CSR_MAX_GAP:  cfg_ff.max_gap_us <= csr_wdata;
            default: ;
         endcase
      end
   end

   fws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item       (front_item),
      .item_valid (front_valid),
      .item_ready (front_ready)
   );

   fws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_item  (front_item),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .rd_item  (queue_item),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready)
   );

   fws_back #(
      .FRAME_SLOTS (FRAME_SLOTS),
      .MAX_SLOTS   (MAX_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (queue_item),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== src/fws_front.sv =====
`default_nettype none
module fws_front (
   input  wire logic            clock,
   input  wire logic            reset,
   fws_req_if.sink              req_bus,
   output fws_pkg::fws_item_type item,
   output logic                 item_valid,
   input  wire logic            item_ready
);

   fws_pkg::fws_item_type item_ff;
   fws_pkg::fws_item_type item_in;
   logic                  valid_ff;

   assign req_bus.ready = !valid_ff || item_ready;
   assign item          = item_ff;
   assign item_valid    = valid_ff;

   // flag checks in priority order; the back end settles monotonic order
   always_comb begin
      item_in           = '0;
      item_in.timestamp = req_bus.timestamp_us;
      item_in.tag       = req_bus.frame_tag;
      item_in.status    = fws_pkg::ST_READY;
      priority if (!req_bus.time_ok) begin
         item_in.reject = 1'b1;
         item_in.status = fws_pkg::ST_BAD_TIME;
      end else if (req_bus.roi_empty) begin
         item_in.reject = 1'b1;
         item_in.status = fws_pkg::ST_EMPTY;
      end else if (req_bus.format_bad) begin
         item_in.reject = 1'b1;
         item_in.status = fws_pkg::ST_BAD_FORMAT;
      end else begin
         item_in.reject = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         valid_ff <= req_bus.valid;
      end
      if (req_bus.valid && req_bus.ready) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/fws_queue.sv =====
`default_nettype none
module fws_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  fws_pkg::fws_item_type wr_item,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   output fws_pkg::fws_item_type rd_item,
   output logic                  rd_valid,
   input  wire logic             rd_ready
);

   localparam int DEPTH = fws_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);

   fws_pkg::fws_item_type slots_ff [DEPTH];
   logic [PW-1:0]         wp_ff;
   logic [PW-1:0]         rp_ff;
   logic [NW-1:0]         fill_ff;
   logic                  push;
   logic                  pop;

   assign wr_ready = fill_ff != NW'(DEPTH);
   assign rd_valid = fill_ff != '0;
   assign rd_item  = slots_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);
         end
         if (pop) begin
            rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + PW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + NW'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - NW'(1);
         end
      end
      if (push) begin
         slots_ff[wp_ff] <= wr_item;
      end
   end

endmodule
`default_nettype wire

// ===== src/fws_div.sv =====
`default_nettype none
module fws_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 26
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] q_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   shifted;
   logic             fits;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, q_ff[NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign done    = done_ff;
   assign quot    = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff <= '0;
         den_ff <= den;
         q_ff   <= num;
      end else if (busy_ff) begin
         rem_ff <= fits ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         q_ff   <= {q_ff[NUM_W-2:0], fits};
      end
   end

endmodule
`default_nettype wire

// ===== src/fws_back.sv =====
`default_nettype none
module fws_back #(
   parameter int FRAME_SLOTS = fws_pkg::FRAME_SLOTS_DEF,
   parameter int MAX_SLOTS   = fws_pkg::MAX_SLOTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  fws_pkg::fws_cfg_type  cfg,
   input  fws_pkg::fws_item_type item,
   input  wire logic             item_valid,
   output logic                  item_ready,
   fws_rsp_if.source             rsp_bus
);

   localparam int AW    = $clog2(FRAME_SLOTS);
   localparam int CW    = $clog2(FRAME_SLOTS + 1);
   localparam int LHS_W = CW + fws_pkg::US_W;
   localparam int NUM_W = LHS_W + fws_pkg::Q_FRAC_W;
   localparam int RHS_W = fws_pkg::MINR_W + fws_pkg::WIN_W;
   localparam int TS_W  = fws_pkg::TS_W;
   localparam int SW    = fws_pkg::SCALED_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_SLOTS);

   typedef enum logic [4:0] {
      S_IDLE, S_NEW_RD, S_NEW_CHK, S_PUSH, S_DROP_RD, S_DROP_CHK,
      S_SCAN_RD, S_SCAN_CHK, S_SCAN_DONE, S_MUL, S_DIV_GO, S_DIV_WAIT,
      S_SMP_RD, S_SMP_MUL, S_SMP_DIST, S_SMP_CMP, S_SMP_OUT,
      S_EMIT_ONE, S_EMIT_SMP
   } state_type;

   function automatic logic [AW-1:0] ring_wrap(input logic [AW-1:0] base,
                                               input logic [CW-1:0] rel);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(rel);
      if (sum >= (CW+1)'(FRAME_SLOTS)) begin
         sum = sum - (CW+1)'(FRAME_SLOTS);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [SW-1:0] abs_diff(input logic [SW-1:0] a,
                                              input logic [SW-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic fws_pkg::fws_result_type stats_result(
      input fws_pkg::status_type          st,
      input logic [fws_pkg::FRAMES_W-1:0] frames,
      input logic [fws_pkg::WIN_W-1:0]    gap,
      input logic [fws_pkg::RATE_W-1:0]   rate);
      fws_pkg::fws_result_type r;
      r        = fws_pkg::plain_result(st);
      r.frames = frames;
      r.gap    = gap;
      r.rate   = rate;
      return r;
   endfunction

   logic [TS_W-1:0]           stamp_mem [FRAME_SLOTS];
   logic [fws_pkg::TAG_W-1:0] tag_mem   [FRAME_SLOTS];

   state_type                 state_ff;
   logic [AW-1:0]             head_ff;
   logic [CW-1:0]             count_ff;
   logic [TS_W-1:0]           ts_ff;
   logic [fws_pkg::TAG_W-1:0] tag_ff;
   logic [TS_W-1:0]           rd_stamp_ff;
   logic [fws_pkg::TAG_W-1:0] rd_tag_ff;
   logic                      drop_en_ff;
   logic [TS_W-1:0]           thr_ff;
   logic [TS_W-1:0]           start_ff;
   logic [CW-1:0]             k_ff;
   logic [CW-1:0]             first_ff;
   logic                      found_ff;
   logic [TS_W-1:0]           fst_stamp_ff;
   logic [fws_pkg::TAG_W-1:0] fst_tag_ff;
   logic [TS_W-1:0]           prev_ff;
   logic [TS_W-1:0]           gap_ff;
   logic [CW-1:0]             n_ff;
   logic [fws_pkg::WIN_W-1:0] span_ff;
   logic [LHS_W-1:0]          lhs_ff;
   logic [RHS_W-1:0]          rhs_ff;
   logic [fws_pkg::SPW_W-1:0] s_ff;
   logic [SW-1:0]             target_ff;
   logic [SW-1:0]             cur_s_ff;
   logic [fws_pkg::TAG_W-1:0] cur_tag_ff;
   logic [SW-1:0]             nxt_s_ff;
   logic [fws_pkg::TAG_W-1:0] nxt_tag_ff;
   logic [SW-1:0]             dcur_ff;
   logic [SW-1:0]             dnxt_ff;
   logic [CW-1:0]             p_ff;
   logic [fws_pkg::SPW_W-1:0] slot_ff;
   logic [fws_pkg::RATE_W-1:0] rate_ff;
   fws_pkg::fws_result_type   rsp_ff;

   logic [CW-1:0]               rel;
   logic [AW-1:0]               raddr;
   logic [AW-1:0]               waddr;
   logic [fws_pkg::WIN_W:0]     two_w;
   logic [TS_W-1:0]             age;
   logic [CW-1:0]               n_c;
   logic [fws_pkg::SPW_W-1:0]   s_c;
   logic [fws_pkg::WIN_W-1:0]   gap_sat;
   logic [fws_pkg::FRAMES_W-1:0] frames_sat;
   logic [fws_pkg::RATE_W-1:0]  rate_sat;
   logic                        div_done;
   logic [NUM_W-1:0]            div_quot;
   logic                        low_rate;

   always_comb begin
      unique case (state_ff)
         S_NEW_RD:  rel = count_ff - CW'(1);
         S_SCAN_RD: rel = k_ff;
         S_SMP_RD:  rel = p_ff + CW'(1);
         default:   rel = '0;
      endcase
   end

   assign raddr = ring_wrap(head_ff, rel);
   assign waddr = (count_ff == DEPTH_C) ? head_ff : ring_wrap(head_ff, count_ff);
   assign two_w = {cfg.window_us, 1'b0};
   assign age   = ts_ff - rd_stamp_ff;
   assign n_c   = count_ff - first_ff;

   always_comb begin
      priority if (cfg.samples_per_window == '0) begin
         s_c = fws_pkg::SPW_W'(1);
      end else if (cfg.samples_per_window > fws_pkg::SPW_W'(MAX_SLOTS)) begin
         s_c = fws_pkg::SPW_W'(MAX_SLOTS);
      end else begin
         s_c = cfg.samples_per_window;
      end
   end

   assign gap_sat    = (gap_ff > TS_W'(fws_pkg::GAP_SAT)) ? fws_pkg::GAP_SAT
                                                          : gap_ff[fws_pkg::WIN_W-1:0];
   assign frames_sat = (32'(n_ff) > 32'(fws_pkg::FRAMES_MAX))
                       ? fws_pkg::FRAMES_W'(fws_pkg::FRAMES_MAX)
                       : fws_pkg::FRAMES_W'(n_ff);
   assign rate_sat   = (div_quot > NUM_W'(fws_pkg::RATE_SAT)) ? fws_pkg::RATE_SAT
                                                              : div_quot[fws_pkg::RATE_W-1:0];
   assign low_rate   = 64'(lhs_ff) < 64'(rhs_ff);

   fws_div #(
      .NUM_W (NUM_W),
      .DEN_W (fws_pkg::WIN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DIV_GO),
      .num   ({lhs_ff, fws_pkg::Q_FRAC_W'(0)}),
      .den   (span_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign item_ready = state_ff == S_IDLE;

   assign rsp_bus.valid          = (state_ff == S_EMIT_ONE) || (state_ff == S_EMIT_SMP);
   assign rsp_bus.status_code    = rsp_ff.status;
   assign rsp_bus.slot_index     = rsp_ff.slot;
   assign rsp_bus.chosen_tag     = rsp_ff.tag;
   assign rsp_bus.window_frames  = rsp_ff.frames;
   assign rsp_bus.largest_gap_us = rsp_ff.gap;
   assign rsp_bus.rate_q8        = rsp_ff.rate;
   assign rsp_bus.last_of_run    = rsp_ff.last;

   // ring storage: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (state_ff == S_PUSH) begin
         stamp_mem[waddr] <= ts_ff;
         tag_mem[waddr]   <= tag_ff;
      end
      rd_stamp_ff <= stamp_mem[raddr];
      rd_tag_ff   <= tag_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  ts_ff  <= item.timestamp;
                  tag_ff <= item.tag;
                  priority if (item.reject) begin
                     rsp_ff   <= fws_pkg::plain_result(item.status);
                     state_ff <= S_EMIT_ONE;
                  end else if (count_ff == '0) begin
                     state_ff <= S_PUSH;
                  end else begin
                     state_ff <= S_NEW_RD;
                  end
               end
            end
            S_NEW_RD: state_ff <= S_NEW_CHK;
            S_NEW_CHK: begin
               if (ts_ff <= rd_stamp_ff) begin
                  rsp_ff   <= fws_pkg::plain_result(fws_pkg::ST_NONMONO);
                  state_ff <= S_EMIT_ONE;
               end else begin
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (count_ff == DEPTH_C) begin
                  head_ff <= ring_wrap(head_ff, CW'(1));
               end else begin
                  count_ff <= count_ff + CW'(1);
               end
               drop_en_ff <= ts_ff >= TS_W'(two_w);
               thr_ff     <= ts_ff - TS_W'(two_w);
               state_ff   <= S_DROP_RD;
            end
            S_DROP_RD: state_ff <= S_DROP_CHK;
            S_DROP_CHK: begin
               priority if (drop_en_ff && count_ff > CW'(1) && rd_stamp_ff < thr_ff) begin
                  head_ff  <= ring_wrap(head_ff, CW'(1));
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_DROP_RD;
               end else if (age < TS_W'(cfg.window_us)) begin
                  rsp_ff   <= fws_pkg::plain_result(fws_pkg::ST_SAMPLING);
                  state_ff <= S_EMIT_ONE;
               end else begin
                  start_ff <= ts_ff - TS_W'(cfg.window_us);
                  k_ff     <= '0;
                  found_ff <= 1'b0;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               // skip frames before the window, then track the largest gap
               if (!found_ff) begin
                  if (rd_stamp_ff >= start_ff) begin
                     found_ff     <= 1'b1;
                     first_ff     <= k_ff;
                     fst_stamp_ff <= rd_stamp_ff;
                     fst_tag_ff   <= rd_tag_ff;
                     gap_ff       <= rd_stamp_ff - start_ff;
                     prev_ff      <= rd_stamp_ff;
                  end
               end else begin
                  if (rd_stamp_ff - prev_ff > gap_ff) begin
                     gap_ff <= rd_stamp_ff - prev_ff;
                  end
                  prev_ff <= rd_stamp_ff;
               end
               k_ff     <= k_ff + CW'(1);
               state_ff <= (k_ff == count_ff - CW'(1)) ? S_SCAN_DONE : S_SCAN_RD;
            end
            S_SCAN_DONE: begin
               if (n_c < CW'(2)) begin
                  rsp_ff   <= fws_pkg::plain_result(fws_pkg::ST_SAMPLING);
                  state_ff <= S_EMIT_ONE;
               end else begin
                  n_ff     <= n_c;
                  span_ff  <= fws_pkg::WIN_W'(ts_ff - fst_stamp_ff);
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               lhs_ff     <= LHS_W'(n_ff - CW'(1)) * LHS_W'(fws_pkg::US_PER_SEC);
               rhs_ff     <= RHS_W'(cfg.min_rate_fps) * RHS_W'(span_ff);
               s_ff       <= s_c;
               target_ff  <= SW'(start_ff) * SW'(s_c);
               cur_s_ff   <= SW'(fst_stamp_ff) * SW'(s_c);
               cur_tag_ff <= fst_tag_ff;
               p_ff       <= first_ff;
               slot_ff    <= '0;
               state_ff   <= S_DIV_GO;
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_done) begin
                  rate_ff <= rate_sat;
                  priority if (low_rate) begin
                     rsp_ff   <= stats_result(fws_pkg::ST_LOW_RATE, frames_sat, gap_sat,
                                              rate_sat);
                     state_ff <= S_EMIT_ONE;
                  end else if (gap_sat > cfg.max_gap_us) begin
                     rsp_ff   <= stats_result(fws_pkg::ST_GAP, frames_sat, gap_sat,
                                              rate_sat);
                     state_ff <= S_EMIT_ONE;
                  end else begin
                     state_ff <= S_SMP_RD;
                  end
               end
            end
            S_SMP_RD: begin
               state_ff <= (32'(p_ff) + 32'd1 < 32'(count_ff)) ? S_SMP_MUL : S_SMP_OUT;
            end
            S_SMP_MUL: begin
               nxt_s_ff   <= SW'(rd_stamp_ff) * SW'(s_ff);
               nxt_tag_ff <= rd_tag_ff;
               state_ff   <= S_SMP_DIST;
            end
            S_SMP_DIST: begin
               dcur_ff  <= abs_diff(cur_s_ff, target_ff);
               dnxt_ff  <= abs_diff(nxt_s_ff, target_ff);
               state_ff <= S_SMP_CMP;
            end
            S_SMP_CMP: begin
               // advance only on strictly closer: ties stay with the earlier frame
               if (dnxt_ff < dcur_ff) begin
                  cur_s_ff   <= nxt_s_ff;
                  cur_tag_ff <= nxt_tag_ff;
                  p_ff       <= p_ff + CW'(1);
                  state_ff   <= S_SMP_RD;
               end else begin
                  state_ff <= S_SMP_OUT;
               end
            end
            S_SMP_OUT: begin
               rsp_ff.status <= fws_pkg::ST_READY;
               rsp_ff.slot   <= fws_pkg::SLOT_W'(slot_ff);
               rsp_ff.tag    <= cur_tag_ff;
               rsp_ff.frames <= frames_sat;
               rsp_ff.gap    <= gap_sat;
               rsp_ff.rate   <= rate_ff;
               rsp_ff.last   <= (slot_ff + fws_pkg::SPW_W'(1)) == s_ff;
               state_ff      <= S_EMIT_SMP;
            end
            S_EMIT_SMP: begin
               if (rsp_bus.ready) begin
                  if (rsp_ff.last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     slot_ff   <= slot_ff + fws_pkg::SPW_W'(1);
                     target_ff <= target_ff + SW'(cfg.window_us);
                     state_ff  <= S_SMP_RD;
                  end
               end
            end
            S_EMIT_ONE: begin
               if (rsp_bus.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("ring count beyond depth");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN_CHK |-> count_ff != '0)
      else $error("window scan on empty ring");

   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT_SMP && rsp_bus.ready && !rsp_ff.last
      |=> slot_ff == $past(slot_ff) + fws_pkg::SPW_W'(1))
      else $error("slot did not advance by one");

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SMP_CMP |-> 32'(p_ff) + 32'd1 < 32'(count_ff))
      else $error("nearest-frame pointer past newest entry");
`endif

endmodule
`default_nettype wire

// ===== sim/fws_checker.sv =====
`default_nettype none
module fws_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [fws_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fws_pkg::WIN_W-1:0]     csr_wdata,
   fws_req_if                                 req,
   fws_rsp_if                                 rsp,
   output int                                 fail_count,
   output int                                 words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING = fws_pkg::FRAME_SLOTS_DEF;

   logic [fws_pkg::TS_W-1:0]   stamp_mem [RING];
   logic [fws_pkg::TAG_W-1:0]  tag_mem [RING];
   int                         oldest;
   int                         fill;

   logic [fws_pkg::WIN_W-1:0]  win_len;
   logic [fws_pkg::SPW_W-1:0]  slot_cfg;
   logic [fws_pkg::MINR_W-1:0] min_fps;
   logic [fws_pkg::WIN_W-1:0]  gap_limit;

   // expected words, indexed by arrival order
   fws_pkg::fws_result_type    exp_words [int];
   int                         wr_idx;
   int                         rd_idx;

   function automatic fws_pkg::fws_result_type status_word(fws_pkg::status_type st,
                                                           logic [63:0] frames,
                                                           logic [63:0] gap,
                                                           logic [63:0] rate);
      fws_pkg::fws_result_type r;
      r        = '0;
      r.status = st;
      r.frames = frames[fws_pkg::FRAMES_W-1:0];
      r.gap    = gap[fws_pkg::WIN_W-1:0];
      r.rate   = rate[fws_pkg::RATE_W-1:0];
      r.last   = 1'b1;
      return r;
   endfunction

   task automatic expect_word(fws_pkg::fws_result_type r);
      exp_words[wr_idx] = r;
      wr_idx++;
   endtask

   // Check one event, push it into the ring if accepted, and queue the words it must produce.
   task automatic sample_frame(logic [fws_pkg::TS_W-1:0] ts, logic ok, logic emp, logic bad,
                               logic [fws_pkg::TAG_W-1:0] tag);
      logic [63:0]               t, thr, start, gap, span, rate, frames, s, target, d;
      logic [63:0]               best_d, ts_s;
      logic [fws_pkg::TAG_W-1:0] best_tag;
      int                        first, n, k, i;
      bit                        have;
      fws_pkg::fws_result_type   r;
      t = 64'(ts);
      if (!ok) begin
         expect_word(status_word(fws_pkg::ST_BAD_TIME, 0, 0, 0));
      end else if (emp) begin
         expect_word(status_word(fws_pkg::ST_EMPTY, 0, 0, 0));
      end else if (bad) begin
         expect_word(status_word(fws_pkg::ST_BAD_FORMAT, 0, 0, 0));
      end else if (fill > 0 && t <= 64'(stamp_mem[(oldest + fill - 1) % RING])) begin
         expect_word(status_word(fws_pkg::ST_NONMONO, 0, 0, 0));
      end else begin
         if (fill >= RING) begin
            stamp_mem[oldest] = ts;
            tag_mem[oldest]   = tag;
            oldest            = (oldest + 1) % RING;
         end else begin
            stamp_mem[(oldest + fill) % RING] = ts;
            tag_mem[(oldest + fill) % RING]   = tag;
            fill++;
         end
         if (t >= 2 * 64'(win_len)) begin
            thr = t - 2 * 64'(win_len);
            while (fill > 1 && 64'(stamp_mem[oldest]) < thr) begin
               oldest = (oldest + 1) % RING;
               fill--;
            end
         end
         if (t - 64'(stamp_mem[oldest]) < 64'(win_len)) begin
            expect_word(status_word(fws_pkg::ST_SAMPLING, 0, 0, 0));
            return;
         end
         start = t - 64'(win_len);
         first = 0;
         while (first < fill && 64'(stamp_mem[(oldest + first) % RING]) < start) first++;
         n = fill - first;
         if (n < 2) begin
            expect_word(status_word(fws_pkg::ST_SAMPLING, 0, 0, 0));
            return;
         end
         gap = 64'(stamp_mem[(oldest + first) % RING]) - start;
         for (k = first + 1; k < fill; k++) begin
            d = 64'(stamp_mem[(oldest + k) % RING]) -
                64'(stamp_mem[(oldest + k - 1) % RING]);
            if (d > gap) gap = d;
         end
         if (gap > 64'(fws_pkg::GAP_SAT)) gap = 64'(fws_pkg::GAP_SAT);
         span = t - 64'(stamp_mem[(oldest + first) % RING]);
         rate = (64'(n - 1) * 64'(fws_pkg::US_PER_SEC) * 64'd256) / span;
         if (rate > 64'(fws_pkg::RATE_SAT)) rate = 64'(fws_pkg::RATE_SAT);
         frames = (n > fws_pkg::FRAMES_MAX) ? 64'(fws_pkg::FRAMES_MAX) : 64'(n);
         if (64'(n - 1) * 64'(fws_pkg::US_PER_SEC) < 64'(min_fps) * span) begin
            expect_word(status_word(fws_pkg::ST_LOW_RATE, frames, gap, rate));
            return;
         end
         if (gap > 64'(gap_limit)) begin
            expect_word(status_word(fws_pkg::ST_GAP, frames, gap, rate));
            return;
         end
         s = 64'(slot_cfg);
         if (s == 0) s = 1;
         if (s > 64'(fws_pkg::MAX_SLOTS_DEF)) s = 64'(fws_pkg::MAX_SLOTS_DEF);
         for (i = 0; i < int'(s); i++) begin
            target   = start * s + 64'(win_len) * 64'(i);
            have     = 0;
            best_d   = 0;
            best_tag = '0;
            for (k = first; k < fill; k++) begin
               ts_s = 64'(stamp_mem[(oldest + k) % RING]) * s;
               d    = (ts_s >= target) ? ts_s - target : target - ts_s;
               if (!have || d < best_d) begin
                  best_d   = d;
                  best_tag = tag_mem[(oldest + k) % RING];
                  have     = 1;
               end
            end
            r      = status_word(fws_pkg::ST_READY, frames, gap, rate);
            r.slot = fws_pkg::SLOT_W'(i);
            r.tag  = best_tag;
            r.last = (i + 1 == int'(s));
            expect_word(r);
         end
      end
   endtask

   always @(posedge clock) begin
      fws_pkg::fws_result_type want, got;
      if (reset) begin
         oldest        = 0;
         fill          = 0;
         win_len       = fws_pkg::WINDOW_RST;
         slot_cfg      = fws_pkg::SAMPLES_RST;
         min_fps       = fws_pkg::MIN_RATE_RST;
         gap_limit     = fws_pkg::MAX_GAP_RST;
         fail_count    = 0;
         wr_idx        = 0;
         rd_idx        = 0;
         exp_words.delete();
      end else begin
         if (csr_we) begin
            case (fws_pkg::csr_index_type'(csr_index))
               fws_pkg::CSR_WINDOW:   win_len   = csr_wdata;
               fws_pkg::CSR_SAMPLES:  slot_cfg  = csr_wdata[fws_pkg::SPW_W-1:0];
               fws_pkg::CSR_MIN_RATE: min_fps   = csr_wdata[fws_pkg::MINR_W-1:0];
               fws_pkg::CSR_MAX_GAP:  gap_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            sample_frame(req.timestamp_us, req.time_ok, req.roi_empty, req.format_bad,
                         req.frame_tag);
         if (rsp.valid && rsp.ready) begin
            got.status = fws_pkg::status_type'(rsp.status_code);
            got.slot   = rsp.slot_index;
            got.tag    = rsp.chosen_tag;
            got.frames = rsp.window_frames;
            got.gap    = rsp.largest_gap_us;
            got.rate   = rsp.rate_q8;
            got.last   = rsp.last_of_run;
            if (rd_idx == wr_idx) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected word: sts %0d slot %0d tag %h", got.status, got.slot,
                           got.tag);
            end else begin
               want = exp_words[rd_idx];
               exp_words.delete(rd_idx);
               rd_idx++;
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.tag !== want.tag || got.frames !== want.frames ||
                   got.gap !== want.gap || got.rate !== want.rate || got.last !== want.last)
               begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: exp sts %0d slot %0d tag %h frm %0d gap %0d",
                              want.status, want.slot, want.tag, want.frames, want.gap,
                              " rate %0d last %0b", want.rate, want.last);
                     $display("          got sts %0d slot %0d tag %h frm %0d gap %0d",
                              got.status, got.slot, got.tag, got.frames, got.gap,
                              " rate %0d last %0b", got.rate, got.last);
                  end
               end
            end
         end
      end
      words_pending = wr_idx - rd_idx;
   end
endmodule
`default_nettype wire

// ===== sim/tb_frame_window_sampler.sv =====
`default_nettype none
module tb_frame_window_sampler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [fws_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fws_pkg::WIN_W-1:0]     csr_wdata;
   int                            fail_count;
   int                            words_pending;
   int                            cycles;
   bit                            stalls_on;
   logic [fws_pkg::TS_W-1:0]      newest_ts;
   logic [fws_pkg::WIN_W-1:0]     cur_window;

   fws_req_if req_bus ();
   fws_rsp_if rsp_bus ();

   frame_window_sampler u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   fws_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("frame_window_sampler regression: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset || !stalls_on) rsp_bus.ready <= 1'b1;
      else rsp_bus.ready <= ($urandom_range(99) >= 38);
   end

   task automatic send(logic [fws_pkg::TS_W-1:0] ts, bit ok, bit emp, bit bad,
                       logic [fws_pkg::TAG_W-1:0] tag);
      if (stalls_on && $urandom_range(99) < 38) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.timestamp_us <= ts;
      req_bus.time_ok      <= ok;
      req_bus.roi_empty    <= emp;
      req_bus.format_bad   <= bad;
      req_bus.frame_tag    <= tag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic frame(logic [fws_pkg::TS_W-1:0] ts, logic [fws_pkg::TAG_W-1:0] tag);
      send(ts, 1, 0, 0, tag);
      newest_ts = ts;
   endtask

   // Drain all words before touching the registers.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(fws_pkg::csr_index_type idx, logic [fws_pkg::WIN_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_regs(logic [fws_pkg::WIN_W-1:0] win, logic [fws_pkg::WIN_W-1:0] spw,
                           logic [fws_pkg::WIN_W-1:0] fps, logic [fws_pkg::WIN_W-1:0] gap);
      settle();
      write_reg(fws_pkg::CSR_WINDOW, win);
      write_reg(fws_pkg::CSR_SAMPLES, spw);
      write_reg(fws_pkg::CSR_MIN_RATE, fps);
      write_reg(fws_pkg::CSR_MAX_GAP, gap);
      cur_window = win;
   endtask

   task automatic random_frames(int count);
      int                       pick, lo, hi;
      bit                       ok, emp, bad;
      logic [fws_pkg::TS_W-1:0] step;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            ok  = $urandom_range(1);
            emp = $urandom_range(1);
            bad = $urandom_range(1);
            if (ok && !emp && !bad) ok = 0;
            send(fws_pkg::TS_W'({$urandom, $urandom}), ok, emp, bad, 16'($urandom));
         end else if (pick < 14) begin
            send(newest_ts - fws_pkg::TS_W'($urandom_range(0, 3)), 1, 0, 0, 16'($urandom));
         end else begin
            lo = (int'(cur_window / 16) > 0) ? int'(cur_window / 16) : 1;
            hi = (int'(cur_window / 3) > lo) ? int'(cur_window / 3) : lo;
            if (pick < 24) hi = 2 * int'(cur_window) + 1;
            step = fws_pkg::TS_W'($urandom_range(lo, hi));
            frame(newest_ts + step, 16'($urandom));
         end
      end
   endtask

   initial begin
      cycles               = 0;
      stalls_on            = 1;
      newest_ts            = '0;
      cur_window           = fws_pkg::WINDOW_RST;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = fws_pkg::CSR_WINDOW;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.timestamp_us = '0;
      req_bus.time_ok      = 1'b0;
      req_bus.roi_empty    = 1'b0;
      req_bus.format_bad   = 1'b0;
      req_bus.frame_tag    = '0;
      rsp_bus.ready        = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // rejections in priority order, then a first frame and a repeat of it
      send(40'hFF_FFFF_FFFF, 0, 1, 1, 16'hFFFF);
      send(40'h0, 1, 1, 1, 16'h0000);
      send(40'h5, 1, 0, 1, 16'h5555);
      frame(40'd0, 16'h0001);
      send(40'd0, 1, 0, 0, 16'hAAAA);

      // two slots, slot 1 sits exactly between two frames
      set_regs(100, 2, 1, 100);
      frame(2000, 16'h000A);
      frame(2040, 16'h000B);
      frame(2060, 16'h000C);
      frame(2100, 16'h000D);
      set_regs(100, 2, 1, 0);
      frame(2200, 16'h000E);
      set_regs(1, 1, 1, 0);
      frame(2301, 16'h0010);
      frame(2302, 16'h0011);
      set_regs(1, 0, 1000, 0);
      frame(2303, 16'h0012);
      set_regs(0, 127, 1000, 60000000);
      frame(2304, 16'h0013);
      set_regs(60000000, 127, 1000, 60000000);
      for (int k = 1; k <= 9; k++) frame(2304 + 40'(k) * 7000000, 16'(k));

      for (int p = 0; p < 6; p++) begin
         stalls_on = (p != 3);
         set_regs(fws_pkg::WIN_W'($urandom_range(1, 5000)),
                  fws_pkg::WIN_W'($urandom_range(0, 127)),
                  fws_pkg::WIN_W'($urandom_range(1, 1000)),
                  fws_pkg::WIN_W'($urandom_range(0, 3000)));
         random_frames(43);
      end
      stalls_on = 1;

      // top of the timestamp range
      set_regs(1000, 5, 1, 60000000);
      for (int k = 0; k < 10; k++)
         frame(40'hFF_FFFF_FFFF - 900 + 40'(k) * 100, 16'(16'hFFFF - k));

      settle();
      if (fail_count == 0) $display("frame_window_sampler regression: pass");
      else $display("frame_window_sampler regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/fws_pkg.sv
src/fws_channels.sv
src/fws_front.sv
src/fws_queue.sv
src/fws_div.sv
src/fws_back.sv
src/frame_window_sampler.sv
sim/fws_checker.sv
sim/tb_frame_window_sampler.sv
